### design/apt_pkg.sv
package apt_pkg;

  // frame size limit and derived statistic widths
  localparam int MAX_PIXELS_LOG2 = 20;
  localparam int CNT_W  = MAX_PIXELS_LOG2 + 1;
  localparam int SUM_W  = MAX_PIXELS_LOG2 + 8;

  localparam int PIX_W  = 8;
  localparam int FRAC_W = 8;
  localparam int THR_W  = 18;
  localparam int MAN_W  = 16;
  localparam int CD_W   = 8;
  localparam int MEAN_W = 16;

  // register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP = 2'd2;

  localparam logic [THR_W-1:0] FULL_SCALE      = 18'd65280;
  localparam logic [THR_W-1:0] DYN_RESET       = 18'd6528;
  localparam logic [MAN_W-1:0] MANUAL_RESET    = 16'd6528;
  localparam logic [CD_W-1:0]  STARTUP_RESET   = 8'd8;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [PIX_W-1:0] peak;
  } frame_stats_t;

  typedef struct packed {
    logic [PIX_W-1:0] level;
    logic             last;
    logic [PIX_W-1:0] pixel;
  } result_t;

endpackage

### design/apt_fifo.sv
module apt_fifo
  import apt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               pop;

  assign full      = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("output queue over depth");

endmodule

### design/apt_front.sv
module apt_front
  import apt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic               in_last,
  input  logic               mode,
  input  logic [MAN_W-1:0]   manual_level,
  input  logic [THR_W-1:0]   dyn_threshold,
  input  logic               upd_busy,
  input  logic               fifo_full,
  output logic               push,
  output result_t            push_data,
  output logic               job_start,
  output frame_stats_t       job
);

  logic [SUM_W-1:0]         frame_sum;
  logic [CNT_W-1:0]         pixel_count;
  logic [PIX_W-1:0]         frame_peak;
  logic [THR_W-1:0]         thr;
  logic [THR_W-FRAC_W-1:0]  lvl_int;
  logic                     below;
  logic                     accept;

  // threshold in force for this item
  always_comb begin
    if (mode) begin
      thr = dyn_threshold;
    end else if (THR_W'(manual_level) > FULL_SCALE) begin
      thr = FULL_SCALE;
    end else begin
      thr = THR_W'(manual_level);
    end
  end

  assign lvl_int = thr[THR_W-1:FRAC_W];
  assign below   = (THR_W'({in_pixel, {FRAC_W{1'b0}}}) < thr);

  assign in_ready = !fifo_full && !upd_busy;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  always_comb begin
    push_data.pixel = below ? '0 : in_pixel;
    push_data.last  = in_last;
    if (lvl_int[THR_W-FRAC_W-1:PIX_W] != '0) begin
      push_data.level = '1;
    end else begin
      push_data.level = lvl_int[PIX_W-1:0];
    end
  end

  // statistics including this item; count saturates at the frame size limit
  always_comb begin
    job.peak = (in_pixel > frame_peak) ? in_pixel : frame_peak;
    if (!pixel_count[CNT_W-1]) begin
      job.sum = frame_sum + SUM_W'(in_pixel);
      job.cnt = pixel_count + 1'b1;
    end else begin
      job.sum = frame_sum;
      job.cnt = pixel_count;
    end
  end

  assign job_start = accept && in_last && mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sum   <= '0;
      pixel_count <= '0;
      frame_peak  <= '0;
    end else if (accept) begin
      if (in_last) begin
        frame_sum   <= '0;
        pixel_count <= '0;
        frame_peak  <= '0;
      end else begin
        frame_sum   <= job.sum;
        pixel_count <= job.cnt;
        frame_peak  <= job.peak;
      end
    end
  end

endmodule

### design/apt_update.sv
module apt_update
  import apt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  frame_stats_t     job,
  input  logic             cd_load,
  input  logic [CD_W-1:0]  cd_value,
  output logic             busy,
  output logic [THR_W-1:0] dyn_threshold
);

  localparam int DIVD_W  = SUM_W + FRAC_W;
  localparam int STEP_W  = $clog2(MEAN_W);
  localparam int PROD_W  = 26;
  localparam int RECIP_W = 24;
  localparam int MUL_W   = PROD_W + RECIP_W;

  // peak*1.8 in Q.8 is (peak*4608 + 5) / 10; the decay divides by 200 as >>3 then /25
  localparam logic [PROD_W-1:0]  PEAK_GAIN  = 26'd4608;
  localparam logic [PROD_W-1:0]  ROUND10    = 26'd5;
  localparam logic [PROD_W-1:0]  DECAY_KEEP = 26'd199;
  localparam logic [PROD_W-1:0]  DECAY_BIAS = 26'd100;
  localparam logic [RECIP_W-1:0] RECIP10    = 24'd1677722;
  localparam logic [RECIP_W-1:0] RECIP25    = 24'd10737419;
  localparam int SHIFT10 = 24;
  localparam int SHIFT25 = 28;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;

  localparam logic [2:0] BR_INIT  = 3'd0;
  localparam logic [2:0] BR_HOLD  = 3'd1;
  localparam logic [2:0] BR_JUMP  = 3'd2;
  localparam logic [2:0] BR_DECAY = 3'd3;
  localparam logic [2:0] BR_KEEP  = 3'd4;

  logic [2:0]        state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W-1:0]  rem;
  logic [MEAN_W-1:0] dvd_lo;
  logic [MEAN_W-1:0] mean;
  logic [PIX_W-1:0]  peak;
  logic [CD_W-1:0]   countdown;
  logic [THR_W-1:0]  peak_track;
  logic [2:0]        branch;
  logic [PROD_W-1:0] prod;
  logic [THR_W-1:0]  quot;

  logic [CNT_W-1:0]  div_init;
  logic [DIVD_W-1:0] dividend;
  logic [CNT_W:0]    trial;
  logic              q_bit;
  logic [THR_W-1:0]  peak_q;
  logic [PROD_W-1:0] mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [MUL_W-1:0]  mul_p;
  logic [THR_W:0]    mid_sum;
  logic [THR_W:0]    twice_less;
  logic [THR_W-1:0]  track_sel;

  assign busy = (state != ST_IDLE);

  // rounded mean: the quotient is known to fit MEAN_W bits, so only those are iterated
  assign div_init = (job.cnt == '0) ? CNT_W'(1) : job.cnt;
  assign dividend = {job.sum, {FRAC_W{1'b0}}} + DIVD_W'(div_init >> 1);
  assign trial    = {rem, dvd_lo[MEAN_W-1]};
  assign q_bit    = (trial >= {1'b0, divisor});

  assign peak_q = THR_W'({peak, {FRAC_W{1'b0}}});

  always_comb begin
    if (branch == BR_INIT) begin
      mul_a = prod;
      mul_b = RECIP10;
    end else begin
      mul_a = prod >> 3;
      mul_b = RECIP25;
    end
    mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  always_comb begin
    case (branch)
      BR_JUMP:  track_sel = peak_q;
      BR_DECAY: track_sel = quot;
      default:  track_sel = peak_track;
    endcase
    mid_sum    = (THR_W+1)'(mean) + (THR_W+1)'(track_sel) + 1'b1;
    twice_less = {quot, 1'b0} - (THR_W+1)'(mean);
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          divisor <= div_init;
          rem     <= CNT_W'(dividend[DIVD_W-1:MEAN_W]);
          dvd_lo  <= dividend[MEAN_W-1:0];
          mean    <= '0;
          peak    <= job.peak;
          step    <= '0;
        end
      end
      ST_DIV: begin
        if (q_bit) begin
          rem <= CNT_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[CNT_W-1:0];
        end
        mean   <= {mean[MEAN_W-2:0], q_bit};
        dvd_lo <= {dvd_lo[MEAN_W-2:0], 1'b0};
        step   <= step + 1'b1;
      end
      ST_MUL1: begin
        if (countdown != '0) begin
          branch <= (countdown == CD_W'(1)) ? BR_INIT : BR_HOLD;
          prod   <= PROD_W'(peak) * PEAK_GAIN + ROUND10;
        end else if (peak_q > peak_track) begin
          branch <= BR_JUMP;
        end else if (peak_q > dyn_threshold) begin
          branch <= BR_DECAY;
          prod   <= PROD_W'(peak_track) * DECAY_KEEP + PROD_W'(peak_q) + DECAY_BIAS;
        end else begin
          branch <= BR_KEEP;
        end
      end
      ST_MUL2: begin
        if (branch == BR_INIT) begin
          quot <= mul_p[SHIFT10 +: THR_W];
        end else begin
          quot <= mul_p[SHIFT25 +: THR_W];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      countdown     <= '0;
      dyn_threshold <= DYN_RESET;
      peak_track    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cd_load) begin
            countdown <= cd_value;
          end
          if (start) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == STEP_W'(MEAN_W - 1)) begin
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          if (countdown != '0) begin
            countdown <= countdown - 1'b1;
          end
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          case (branch)
            BR_INIT: begin
              dyn_threshold <= quot;
              peak_track    <= twice_less[THR_W-1:0];
            end
            BR_HOLD: begin
              dyn_threshold <= FULL_SCALE;
            end
            default: begin
              peak_track    <= track_sel;
              dyn_threshold <= mid_sum[THR_W:1];
            end
          endcase
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/adaptive_pixel_threshold.sv
// an accepted item is written into the output queue, whose head drives the output
// throughput: one item per cycle inside a frame while the output queue has room; after a
//   dynamic-mode frame end the input pauses (restoring divide for the mean, 3 update steps)
// a 4-entry output queue lets the input keep flowing while the output is stalled
// reset: synchronous, active high; control registers take their reset values, no clearing pass
module adaptive_pixel_threshold
  import apt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] pixel
  input  logic                  s_axis_tlast,   // frame_last
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [7:0] out_pixel, [15:8] level
  output logic                  m_axis_tlast,   // out_frame_last
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic             mode;
  logic [MAN_W-1:0] manual_level;
  logic [CD_W-1:0]  startup_frames;

  logic             cfg_write;
  logic             cd_load;
  logic [THR_W-1:0] dyn_threshold;
  logic             upd_busy;
  logic             fifo_full;
  logic             push;
  result_t          push_data;
  result_t          out_data;
  logic             job_start;
  frame_stats_t     job;

  // register writes wait while a frame-end update is running
  assign cfg_ready = !upd_busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // entering (or re-entering) dynamic mode restarts the start-up countdown
  assign cd_load = cfg_write && (cfg_index == REG_MODE) && cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= 1'b1;
      manual_level   <= MANUAL_RESET;
      startup_frames <= STARTUP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:    mode           <= cfg_data[0];
        REG_MANUAL:  manual_level   <= cfg_data[MAN_W-1:0];
        REG_STARTUP: startup_frames <= cfg_data[CD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: thresholds each item and gathers frame statistics
  apt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_pixel      (s_axis_tdata),
    .in_last       (s_axis_tlast),
    .mode          (mode),
    .manual_level  (manual_level),
    .dyn_threshold (dyn_threshold),
    .upd_busy      (upd_busy),
    .fifo_full     (fifo_full),
    .push          (push),
    .push_data     (push_data),
    .job_start     (job_start),
    .job           (job)
  );

  // back: frame-end mean divide and threshold tracking
  apt_update u_update (
    .clk           (clk),
    .rst           (rst),
    .start         (job_start),
    .job           (job),
    .cd_load       (cd_load),
    .cd_value      (startup_frames),
    .busy          (upd_busy),
    .dyn_threshold (dyn_threshold)
  );

  // result queue towards the output
  apt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {out_data.level, out_data.pixel};
  assign m_axis_tlast = out_data.last;

  // no item may enter while the threshold is being recomputed
  a_hold_during_update: assert property (@(posedge clk) disable iff (rst)
    upd_busy |-> !s_axis_tready)
    else $error("item accepted during threshold update");

  // a frame end in dynamic mode starts the update
  a_frame_end_starts: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast && mode) |=> upd_busy)
    else $error("frame end did not start the update");

  // the dynamic threshold moves only as an update completes
  a_threshold_steady: assert property (@(posedge clk)
    (!rst && !upd_busy) |=> $stable(dyn_threshold))
    else $error("threshold changed outside an update");

endmodule
